// ----- rtl/core/nttp_pkg.sv -----
// Package for the note-to-tone timer block: payload words, config codes,
// pipeline structs and the pitch-factor function. No dependencies.
package nttp_pkg;

    // register indexes on the config port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_TEMPO_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMPO_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_SHIFT = 2'd2;

    localparam logic [8:0] SCALE_RESET = 9'd100;
    localparam logic [23:0] FACTOR_UNITY = 24'd1048576;  // 1.0 in Q4.20

    // duration path: x / 100 == (x * RECIP_100) >> 30 for x < 2^23
    localparam logic [23:0] RECIP_100 = 24'd10737419;
    localparam int RECIP_SHIFT = 30;
    localparam logic signed [17:0] MS_MIN = 18'sd10;
    localparam logic signed [17:0] MS_MAX = 18'sd5000;

    // pitch path, Q19.20 products
    localparam logic [38:0] HZ_LO_Q20 = 39'd30 << 20;
    localparam logic [38:0] HZ_HI_Q20 = 39'd20000 << 20;
    localparam logic [38:0] HALF_Q20 = 39'd1 << 19;

    // 1 MHz tick divided by the played frequency
    localparam int DIV_STAGES = 20;
    localparam logic [DIV_STAGES-1:0] TICK_HZ = 20'd1000000;

    localparam logic [31:0] SEMITONE_Q30 [12] = '{
        32'd1073741824, 32'd1137589835, 32'd1205234447, 32'd1276901417,
        32'd1352829926, 32'd1433273380, 32'd1518500250, 32'd1608794974,
        32'd1704458901, 32'd1805811301, 32'd1913190429, 32'd2026954652
    };

    typedef struct packed {
        logic [14:0] note_freq_hz;
        logic [13:0] note_duration_ms;
    } note_in_t;

    typedef struct packed {
        logic        tone_on;
        logic [14:0] played_freq_hz;
        logic [19:0] period_minus_one;
        logic [18:0] compare_value;
        logic [12:0] play_ms;
    } tone_out_t;

    // live configuration seen by the datapath
    typedef struct packed {
        logic [8:0]  tempo_scale;
        logic [15:0] tempo_offset;
        logic [23:0] factor_q20;
        logic        shift_zero;
    } cfg_t;

    // front end -> divider
    typedef struct packed {
        logic        valid;
        logic        tone_on;
        logic [14:0] played;
        logic [12:0] play_ms;
    } front_t;

    // one divider stage
    typedef struct packed {
        logic                  valid;
        logic                  tone_on;
        logic [14:0]           played;
        logic [12:0]           play_ms;
        logic [14:0]           divisor;
        logic [14:0]           rem;
        logic [DIV_STAGES-1:0] quo;
    } div_t;

    // Q4.20 factor 2^(k/12), k clamped to -24..36
    function automatic logic [23:0] factor_q20(input logic [6:0] k_raw);
        logic [6:0]  biased;
        logic [5:0]  i;
        logic [3:0]  j;
        logic [3:0]  s;
        logic [32:0] sum;
        logic [32:0] shifted;
        biased = k_raw + 7'd24;
        if ($signed(k_raw) < -7'sd24) begin
            i = 6'd0;
        end else if ($signed(k_raw) > 7'sd36) begin
            i = 6'd60;
        end else begin
            i = biased[5:0];
        end
        priority if (i < 6'd12) begin
            j = i[3:0];
            s = 4'd12;
        end else if (i < 6'd24) begin
            j = 4'(i - 6'd12);
            s = 4'd11;
        end else if (i < 6'd36) begin
            j = 4'(i - 6'd24);
            s = 4'd10;
        end else if (i < 6'd48) begin
            j = 4'(i - 6'd36);
            s = 4'd9;
        end else if (i < 6'd60) begin
            j = 4'(i - 6'd48);
            s = 4'd8;
        end else begin
            j = 4'd0;
            s = 4'd7;
        end
        sum = {1'b0, SEMITONE_Q30[j]} + (33'd1 << (s - 4'd1));
        shifted = sum >> s;
        return shifted[23:0];
    endfunction

endpackage

// ----- rtl/core/nttp_cfg.sv -----
// Config registers for the note-to-tone block; pitch factor is looked up
// on write and held. Depends on nttp_pkg.
module nttp_cfg
    import nttp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TEMPO_SCALE:
                begin
                    cfg_next.tempo_scale = cfg_data[8:0];
                end
                REG_TEMPO_OFFSET:
                begin
                    cfg_next.tempo_offset = cfg_data;
                end
                REG_PITCH_SHIFT:
                begin
                    cfg_next.factor_q20 = factor_q20(cfg_data[6:0]);
                    cfg_next.shift_zero = (cfg_data[6:0] == 7'd0);
                end
                default:
                begin
                    cfg_next = cfg_reg;  // unknown index: ignored
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tempo_scale  <= SCALE_RESET;
            cfg_reg.tempo_offset <= '0;
            cfg_reg.factor_q20   <= FACTOR_UNITY;
            cfg_reg.shift_zero   <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/nttp_front.sv -----
// Front end: three stages of duration scaling and pitch transposition.
// Depends on nttp_pkg.
module nttp_front
    import nttp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  note_in_t note,
    input  cfg_t     cfg,
    output front_t   front
);

    // stage 1: both products
    logic        s1_valid_reg;
    logic        s1_rest_reg;
    logic [14:0] s1_freq_reg;
    logic [22:0] s1_dur_prod_reg;
    logic [38:0] s1_freq_prod_reg;

    // stage 2: reciprocal product, played frequency
    logic        s2_valid_reg;
    logic        s2_rest_reg;
    logic [14:0] s2_played_reg;
    logic [46:0] s2_ms_prod_reg;
    logic [14:0] s2_played_next;
    logic [38:0] clamped;
    logic [38:0] rounded;

    // stage 3: offset and clamp
    front_t       s3_reg;
    front_t       s3_next;
    logic [16:0]  ms_quot;
    logic signed [17:0] ms_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_rest_reg      <= (note.note_freq_hz == 15'd0);
        s1_freq_reg      <= note.note_freq_hz;
        s1_dur_prod_reg  <= 23'(note.note_duration_ms) * 23'(cfg.tempo_scale);
        s1_freq_prod_reg <= 39'(note.note_freq_hz) * 39'(cfg.factor_q20);
    end

    always_comb
    begin
        priority if (s1_freq_prod_reg < HZ_LO_Q20)
        begin
            clamped = HZ_LO_Q20;
        end
        else if (s1_freq_prod_reg > HZ_HI_Q20)
        begin
            clamped = HZ_HI_Q20;
        end
        else
        begin
            clamped = s1_freq_prod_reg;
        end
        rounded = clamped + HALF_Q20;
        if (s1_rest_reg)
        begin
            s2_played_next = 15'd0;
        end
        else if (cfg.shift_zero)
        begin
            s2_played_next = s1_freq_reg;
        end
        else
        begin
            s2_played_next = rounded[34:20];
        end
    end

    always_ff @(posedge clk)
    begin
        s2_rest_reg    <= s1_rest_reg;
        s2_played_reg  <= s2_played_next;
        s2_ms_prod_reg <= 47'(s1_dur_prod_reg) * 47'(RECIP_100);
    end

    always_comb
    begin
        ms_quot = s2_ms_prod_reg[RECIP_SHIFT+16:RECIP_SHIFT];
        ms_sum  = $signed({1'b0, ms_quot})
                + $signed({{2{cfg.tempo_offset[15]}}, cfg.tempo_offset});
        s3_next.valid   = s2_valid_reg;
        s3_next.tone_on = !s2_rest_reg;
        s3_next.played  = s2_played_reg;
        priority if (ms_sum < MS_MIN)
        begin
            s3_next.play_ms = 13'(MS_MIN);
        end
        else if (ms_sum > MS_MAX)
        begin
            s3_next.play_ms = 13'(MS_MAX);
        end
        else
        begin
            s3_next.play_ms = ms_sum[12:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_reg <= '0;
        end
        else
        begin
            s3_reg <= s3_next;
        end
    end

    assign front = s3_reg;

endmodule

// ----- rtl/core/nttp_div.sv -----
// Pipelined restoring divider: 1 MHz tick / played frequency, one quotient
// bit per stage. Depends on nttp_pkg.
module nttp_div
    import nttp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  front_t front,
    output div_t   quot
);

    div_t entry;
    div_t stage_reg  [DIV_STAGES];
    div_t stage_next [DIV_STAGES];

    // rest words divide by one; the result is masked later
    always_comb
    begin
        entry.valid   = front.valid;
        entry.tone_on = front.tone_on;
        entry.played  = front.played;
        entry.play_ms = front.play_ms;
        entry.divisor = front.tone_on ? front.played : 15'd1;
        entry.rem     = '0;
        entry.quo     = '0;
    end

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_stage
        div_t        prev;
        logic [15:0] rem_sh;
        logic [16:0] diff;
        logic        qbit;

        if (g == 0)
        begin : g_first
            assign prev = entry;
        end
        else
        begin : g_rest
            assign prev = stage_reg[g-1];
        end

        always_comb
        begin
            rem_sh = {prev.rem, TICK_HZ[DIV_STAGES-1-g]};
            diff   = {1'b0, rem_sh} - {2'b00, prev.divisor};
            qbit   = !diff[16];
            stage_next[g]     = prev;
            stage_next[g].rem = qbit ? diff[14:0] : rem_sh[14:0];
            stage_next[g].quo = {prev.quo[DIV_STAGES-2:0], qbit};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stage_reg[g] <= '0;
            end
            else
            begin
                stage_reg[g] <= stage_next[g];
            end
        end
    end

    assign quot = stage_reg[DIV_STAGES-1];

endmodule

// ----- rtl/core/note_to_tone_timer_params_top.sv -----
// Note to PWM timer settings: top level, depends on nttp_pkg, nttp_cfg,
// nttp_front and nttp_div.
// A word taken with start passes 3 front stages, 20 divider stages and 1 output
// register before it shows on result with done high.
// Throughput: one word per cycle; busy stays low, done pulses one cycle.
// Reset (rst_n, async, low): pipeline emptied, config back to 100 %, 0 ms, 0 st.
module note_to_tone_timer_params_top
    import nttp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  note_in_t              note,
    output logic                  done,
    output tone_out_t             result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg;
    front_t    front;
    div_t      quot;
    logic      done_reg;
    tone_out_t result_reg;
    tone_out_t result_next;

    // fully pipelined, nothing downstream can stall it
    assign busy = 1'b0;

    nttp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // duration scale/offset/clamp and pitch multiply/clamp/round
    nttp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .note     (note),
        .cfg      (cfg),
        .front    (front)
    );

    // ticks = 1e6 / played frequency
    nttp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .front (front),
        .quot  (quot)
    );

    // timer words: reload = ticks - 1, compare = ticks / 2; rests read zero
    always_comb
    begin
        result_next.tone_on = quot.tone_on;
        result_next.play_ms = quot.play_ms;
        if (quot.tone_on)
        begin
            result_next.played_freq_hz   = quot.played;
            result_next.period_minus_one = quot.quo - 20'd1;
            result_next.compare_value    = quot.quo[DIV_STAGES-1:1];
        end
        else
        begin
            result_next.played_freq_hz   = '0;
            result_next.period_minus_one = '0;
            result_next.compare_value    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= quot.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
